// File: sv/cffg_pkg.sv
`default_nettype none
package cffg_pkg;

	// widths of the item fields and configuration registers
	localparam int unsigned OpW       = 3;
	localparam int unsigned LenW      = 4;
	localparam int unsigned PayW      = 64;
	localparam int unsigned IdW       = 29;
	localparam int unsigned StdIdW    = 11;
	localparam int unsigned TicksW    = 20;
	localparam int unsigned ModeW     = 3;
	localparam int unsigned MaskW     = 8;
	localparam int unsigned CfgIdxW   = 3;
	localparam int unsigned CfgDataW  = 64;
	localparam int unsigned InDataW   = 72;
	localparam int unsigned OutDataW  = 104;
	localparam int unsigned OutUserW  = 3;

	localparam int unsigned MaxBytesDefault = 8;

	// mode_flags bits
	localparam int unsigned ModeExtBit   = 0;
	localparam int unsigned ModeUpBit    = 1;
	localparam int unsigned ModeMatchBit = 2;

	typedef enum logic [OpW-1:0] {
		OP_TICK   = 3'd0,
		OP_RX     = 3'd1,
		OP_START  = 3'd2,
		OP_STOP   = 3'd3,
		OP_PAUSE  = 3'd4,
		OP_RESUME = 3'd5
	} op_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_RANGE_LOW    = 3'd0,
		CFG_RANGE_HIGH   = 3'd1,
		CFG_MATCH_DATA   = 3'd2,
		CFG_MATCH_MASK   = 3'd3,
		CFG_FRAME_ID     = 3'd4,
		CFG_FRAME_LENGTH = 3'd5,
		CFG_PERIOD_TICKS = 3'd6,
		CFG_MODE_FLAGS   = 3'd7
	} cfg_idx_t;

	// control into the payload stepper
	typedef struct packed {
		logic [LenW-1:0] len;
		logic            up_first;
	} step_ctl_t;

endpackage
`default_nettype wire

// File: sv/cffg_step.sv
`default_nettype none
module cffg_step #(
	parameter int unsigned MAX_BYTES = cffg_pkg::MaxBytesDefault
) (
	input  wire logic [MAX_BYTES*8-1:0] payload,
	input  wire logic [MAX_BYTES*8-1:0] lo_bound,
	input  wire logic [MAX_BYTES*8-1:0] hi_bound,
	input  wire cffg_pkg::step_ctl_t    ctl,
	output logic      [MAX_BYTES*8-1:0] payload_next,
	output logic                        wrapped
);
	import cffg_pkg::*;

	localparam int unsigned IW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

	// odometer carry ripples through the digits in stepping order
	always_comb begin
		logic [LenW-1:0] pos;
		logic [IW-1:0]   idx;
		logic [7:0]      d;
		logic [7:0]      lo;
		logic [7:0]      hi;
		logic [8:0]      inc;
		logic            carry;
		logic            live;
		payload_next = payload;
		carry = 1'b1;
		for (int k = 0; k < MAX_BYTES; k++) begin
			pos = ctl.up_first ? (ctl.len - LenW'(1) - LenW'(k)) : LenW'(k);
			idx = pos[IW-1:0];
			d   = payload[idx*8 +: 8];
			lo  = lo_bound[idx*8 +: 8];
			hi  = hi_bound[idx*8 +: 8];
			// fixed digits pass the carry on, except the first digit
			live = (LenW'(k) < ctl.len) && carry && ((k == 0) || (lo != hi));
			inc = {1'b0, d} + 9'd1;
			if (live) begin
				if (inc <= {1'b0, hi}) begin
					payload_next[idx*8 +: 8] = inc[7:0];
					carry = 1'b0;
				end else begin
					payload_next[idx*8 +: 8] = lo;
				end
			end
		end
		wrapped = carry;
	end

endmodule
`default_nettype wire

// File: sv/can_frame_fuzz_generator.sv
// can frame fuzz generator
// - s_axis carries one command item: tuser holds op (tick, received frame,
//   start, stop, pause, resume); tdata holds rx_length and rx_payload
// - m_axis carries one result item when a frame is emitted or a run ends:
//   tuser holds tx_valid, done_res, done_by_match; tdata holds the frame
// - cfg_we / cfg_index / cfg_data write one register per cycle; write only
//   while no item is in flight
// - an accepted item sits in the input register, is evaluated by the
//   payload stepper and match compare, and its result lands in the
//   output register
// - throughput is one item per clock unless m_axis stalls; the single state
//   update per item (elapsed count, payload odometer, run flags) sets that figure
// - items that cause no result (most ticks, start, stop, ...) produce nothing
//   on m_axis
// - when m_axis stalls with a result held, the input register keeps its item
//   and s_axis_tready drops until the held result is taken
// - reset clears the run flags, elapsed count, payload and registers to their
//   idle values (frame_length resets to one)
`default_nettype none
module can_frame_fuzz_generator #(
	parameter int unsigned MAX_BYTES = cffg_pkg::MaxBytesDefault
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// config write port
	input  wire logic                          cfg_we,
	input  wire logic [cffg_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [cffg_pkg::CfgDataW-1:0] cfg_data,
	// command items
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [cffg_pkg::InDataW-1:0]  s_axis_tdata,  // rx_length, rx_payload, zero pad
	input  wire logic [cffg_pkg::OpW-1:0]      s_axis_tuser,  // op
	// result items
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [cffg_pkg::OutDataW-1:0]      m_axis_tdata,  // tx_id, tx_extended, tx_length,
	                                                          // tx_payload, zero pad
	output logic [cffg_pkg::OutUserW-1:0]      m_axis_tuser   // tx_valid, done_res, done_by_match
);
	import cffg_pkg::*;

	localparam int unsigned PW = MAX_BYTES * 8;

	// configuration registers
	logic [PayW-1:0]   range_low_q;
	logic [PayW-1:0]   range_high_q;
	logic [PayW-1:0]   match_data_q;
	logic [MaskW-1:0]  match_mask_q;
	logic [IdW-1:0]    frame_id_q;
	logic [LenW-1:0]   frame_length_q;
	logic [TicksW-1:0] period_ticks_q;
	logic [ModeW-1:0]  mode_flags_q;

	// run state
	logic              running_q;
	logic              paused_q;
	logic              finished_q;
	logic [PW-1:0]     payload_q;
	logic [TicksW-1:0] elapsed_q;

	// input register
	logic              valid_s1;
	logic [OpW-1:0]    op_s1;
	logic [LenW-1:0]   rx_len_s1;
	logic [PayW-1:0]   rx_pay_s1;

	logic advance;
	logic in_fire;

	assign advance       = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q    <= '0;
			range_high_q   <= '0;
			match_data_q   <= '0;
			match_mask_q   <= '0;
			frame_id_q     <= '0;
			frame_length_q <= LenW'(1);
			period_ticks_q <= '0;
			mode_flags_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_RANGE_LOW:    range_low_q    <= cfg_data;
				CFG_RANGE_HIGH:   range_high_q   <= cfg_data;
				CFG_MATCH_DATA:   match_data_q   <= cfg_data;
				CFG_MATCH_MASK:   match_mask_q   <= cfg_data[MaskW-1:0];
				CFG_FRAME_ID:     frame_id_q     <= cfg_data[IdW-1:0];
				CFG_FRAME_LENGTH: frame_length_q <= cfg_data[LenW-1:0];
				CFG_PERIOD_TICKS: period_ticks_q <= cfg_data[TicksW-1:0];
				CFG_MODE_FLAGS:   mode_flags_q   <= cfg_data[ModeW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1     <= s_axis_tuser;
			rx_len_s1 <= s_axis_tdata[LenW-1:0];
			rx_pay_s1 <= s_axis_tdata[LenW +: PayW];
		end
	end

	// effective frame length: zero reads as one, clamp to the byte count
	logic [LenW-1:0] eff_len;
	always_comb begin
		if (frame_length_q == '0) begin
			eff_len = LenW'(1);
		end else if (frame_length_q > LenW'(MAX_BYTES)) begin
			eff_len = LenW'(MAX_BYTES);
		end else begin
			eff_len = frame_length_q;
		end
	end

	// payload odometer step
	step_ctl_t     step_ctl;
	logic [PW-1:0] payload_next;
	logic          wrapped;

	assign step_ctl.len      = eff_len;
	assign step_ctl.up_first = mode_flags_q[ModeUpBit];

	cffg_step #(
		.MAX_BYTES(MAX_BYTES)
	) u_step (
		.payload      (payload_q),
		.lo_bound     (range_low_q[PW-1:0]),
		.hi_bound     (range_high_q[PW-1:0]),
		.ctl          (step_ctl),
		.payload_next (payload_next),
		.wrapped      (wrapped)
	);

	// bytes at and above the frame length go out as zero
	logic [PW-1:0] payload_masked;
	always_comb begin
		for (int b = 0; b < MAX_BYTES; b++) begin
			payload_masked[b*8 +: 8] = (LenW'(b) < eff_len) ? payload_q[b*8 +: 8] : 8'd0;
		end
	end

	// received frame compare: enough bytes, masked bytes below rx length match
	logic [LenW-1:0] mask_count;
	logic            bytes_equal;
	always_comb begin
		mask_count  = '0;
		bytes_equal = 1'b1;
		for (int j = 0; j < 8; j++) begin
			mask_count = mask_count + LenW'(match_mask_q[j]);
			if (match_mask_q[j] && (LenW'(j) < rx_len_s1)
			    && (rx_pay_s1[j*8 +: 8] != match_data_q[j*8 +: 8])) begin
				bytes_equal = 1'b0;
			end
		end
	end

	logic active;
	assign active = running_q && !paused_q && !finished_q;

	// tick bookkeeping: elapsed count saturates at the period
	logic [TicksW-1:0] elapsed_inc;
	logic              tick_emit;
	assign elapsed_inc = (elapsed_q >= period_ticks_q) ? period_ticks_q : elapsed_q + TicksW'(1);
	assign tick_emit   = elapsed_inc >= period_ticks_q;

	logic rx_match;
	assign rx_match = mode_flags_q[ModeMatchBit] && (rx_len_s1 >= mask_count) && bytes_equal;

	// per-item decision
	logic              res_valid;
	logic              res_frame;
	logic              res_done;
	logic              res_by_match;
	logic              running_d;
	logic              paused_d;
	logic              finished_d;
	logic [PW-1:0]     payload_d;
	logic [TicksW-1:0] elapsed_d;

	always_comb begin
		res_valid    = 1'b0;
		res_frame    = 1'b0;
		res_done     = 1'b0;
		res_by_match = 1'b0;
		running_d    = running_q;
		paused_d     = paused_q;
		finished_d   = finished_q;
		payload_d    = payload_q;
		elapsed_d    = elapsed_q;
		case (op_s1)
			OP_TICK: begin
				if (active) begin
					elapsed_d = elapsed_inc;
					if (tick_emit) begin
						res_valid = 1'b1;
						res_frame = 1'b1;
						elapsed_d = '0;
						payload_d = payload_next;
						if (wrapped) begin
							res_done   = 1'b1;
							finished_d = 1'b1;
							running_d  = 1'b0;
							paused_d   = 1'b0;
						end
					end
				end
			end
			OP_RX: begin
				if (active && rx_match) begin
					res_valid    = 1'b1;
					res_done     = 1'b1;
					res_by_match = 1'b1;
					finished_d   = 1'b1;
					running_d    = 1'b0;
					paused_d     = 1'b0;
				end
			end
			OP_START: begin
				running_d  = 1'b1;
				paused_d   = 1'b0;
				finished_d = 1'b0;
				payload_d  = range_low_q[PW-1:0];
				elapsed_d  = '0;
			end
			OP_STOP: begin
				running_d = 1'b0;
				paused_d  = 1'b0;
			end
			OP_PAUSE:  paused_d = 1'b1;
			OP_RESUME: paused_d = 1'b0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= 1'b0;
			paused_q   <= 1'b0;
			finished_q <= 1'b0;
			payload_q  <= '0;
			elapsed_q  <= '0;
		end else if (advance) begin
			running_q  <= running_d;
			paused_q   <= paused_d;
			finished_q <= finished_d;
			payload_q  <= payload_d;
			elapsed_q  <= elapsed_d;
		end
	end

	// result register
	logic             ext;
	logic [IdW-1:0]   id_out;
	assign ext    = mode_flags_q[ModeExtBit];
	assign id_out = ext ? frame_id_q : {{(IdW-StdIdW){1'b0}}, frame_id_q[StdIdW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (advance && res_valid) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			m_axis_tuser <= {res_by_match, res_done, res_frame};
			if (res_frame) begin
				m_axis_tdata <= {(OutDataW-IdW-1-LenW-PayW)'(0), PayW'(payload_masked),
				                 eff_len, ext, id_out};
			end else begin
				m_axis_tdata <= '0;
			end
		end
	end

endmodule
`default_nettype wire

// File: sim/can_frame_fuzz_generator_tb.sv
`timescale 1ns / 100ps
module can_frame_fuzz_generator_tb;
	import cffg_pkg::*;

	// spare op codes the block must ignore
	localparam logic [OpW-1:0] OP_SPARE_A = 3'd6;
	localparam logic [OpW-1:0] OP_SPARE_B = 3'd7;
	// cycles to let a result-free item clear the pipe
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned PERIOD_MAX = 1000000;
	localparam int unsigned TRAFFIC_PER_PHASE = 500;
	localparam int unsigned HOLD_CYCLES = 300;

	typedef struct packed {
		logic            tx_valid;
		logic [IdW-1:0]  tx_id;
		logic            tx_extended;
		logic [LenW-1:0] tx_length;
		logic [PayW-1:0] tx_payload;
		logic            done_res;
		logic            done_by_match;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [InDataW-1:0] s_axis_tdata = '0;
	logic [OpW-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OutDataW-1:0] m_axis_tdata;
	logic [OutUserW-1:0] m_axis_tuser;

	// predicted block configuration
	logic [PayW-1:0]   cfg_lo = '0;
	logic [PayW-1:0]   cfg_hi = '0;
	logic [PayW-1:0]   cfg_match = '0;
	logic [MaskW-1:0]  cfg_mask = '0;
	logic [IdW-1:0]    cfg_id = '0;
	logic [LenW-1:0]   cfg_len = 4'd1;
	logic [TicksW-1:0] cfg_period = '0;
	logic [ModeW-1:0]  cfg_mode = '0;

	// predicted run state
	bit              gen_running = 1'b0;
	bit              gen_paused = 1'b0;
	bit              gen_finished = 1'b0;
	logic [PayW-1:0] odometer = '0;
	logic [TicksW-1:0] ticks_elapsed = '0;

	frame_result_t frames_due[$];
	int unsigned errors = 0;
	int unsigned items_sent = 0;
	int unsigned src_idle_pct = 15;
	int unsigned snk_idle_pct = 80;
	int unsigned hold_left = 0;
	int unsigned hold_requests = 0;
	int unsigned hold_served = 0;

	can_frame_fuzz_generator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------

	// frame length clamped to 1..max bytes
	function automatic int unsigned frame_bytes();
		int unsigned n;
		n = cfg_len;
		if (n < 1) n = 1;
		if (n > MaxBytesDefault) n = MaxBytesDefault;
		return n;
	endfunction

	// one digit step; 1 when it stepped without carry
	function automatic bit digit_step(int unsigned idx);
		int unsigned d;
		d = odometer[8*idx +: 8];
		if (d + 1 <= cfg_hi[8*idx +: 8]) begin
			odometer[8*idx +: 8] = 8'(d + 1);
			return 1'b1;
		end
		odometer[8*idx +: 8] = cfg_lo[8*idx +: 8];
		return 1'b0;
	endfunction

	// advance the odometer; 1 once every digit has wrapped
	function automatic bit odometer_advance(int unsigned n);
		bit up;
		int unsigned idx;
		up = cfg_mode[ModeUpBit];
		idx = up ? n - 1 : 0;
		// the first digit steps even when its bounds are equal
		if (digit_step(idx)) return 1'b0;
		for (int unsigned k = 1; k < n; k++) begin
			idx = up ? n - 1 - k : k;
			if (cfg_lo[8*idx +: 8] == cfg_hi[8*idx +: 8]) continue;
			if (digit_step(idx)) return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic model_apply_command(input logic [OpW-1:0] op, input logic [LenW-1:0] rx_len,
			input logic [PayW-1:0] rx_pay);
		frame_result_t r;
		bit active;
		bit hit;
		int unsigned n;
		int unsigned lim;
		logic [PayW-1:0] keep_mask;
		r = '0;
		active = gen_running && !gen_paused && !gen_finished;
		case (op)
			OP_TICK: begin
				if (active) begin
					// elapsed count saturates at the period
					if (ticks_elapsed >= cfg_period) ticks_elapsed = cfg_period;
					else ticks_elapsed = ticks_elapsed + 1'b1;
					if (ticks_elapsed >= cfg_period) begin
						n = frame_bytes();
						keep_mask = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
						r.tx_valid = 1'b1;
						r.tx_extended = cfg_mode[ModeExtBit];
						r.tx_id = cfg_mode[ModeExtBit] ? cfg_id : IdW'(cfg_id[StdIdW-1:0]);
						r.tx_length = LenW'(n);
						r.tx_payload = odometer & keep_mask;
						ticks_elapsed = '0;
						if (odometer_advance(n)) begin
							gen_finished = 1'b1;
							gen_running = 1'b0;
							gen_paused = 1'b0;
							r.done_res = 1'b1;
						end
						frames_due.push_back(r);
					end
				end
			end
			OP_RX: begin
				if (active && cfg_mode[ModeMatchBit]) begin
					// length must reach the number of compared bytes
					if (rx_len >= $countones(cfg_mask)) begin
						hit = 1'b1;
						lim = (rx_len > 8) ? 8 : rx_len;
						for (int unsigned j = 0; j < lim; j++)
							if (cfg_mask[j] && rx_pay[8*j +: 8] != cfg_match[8*j +: 8])
								hit = 1'b0;
						if (hit) begin
							gen_finished = 1'b1;
							gen_running = 1'b0;
							gen_paused = 1'b0;
							r.done_res = 1'b1;
							r.done_by_match = 1'b1;
							frames_due.push_back(r);
						end
					end
				end
			end
			OP_START: begin
				gen_running = 1'b1;
				gen_paused = 1'b0;
				gen_finished = 1'b0;
				odometer = cfg_lo;
				ticks_elapsed = '0;
			end
			OP_STOP: begin
				gen_running = 1'b0;
				gen_paused = 1'b0;
			end
			OP_PAUSE: begin
				gen_paused = 1'b1;
			end
			OP_RESUME: begin
				gen_paused = 1'b0;
			end
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------
	// drivers
	// ---------------------------------------------------------------

	// register write, block must be idle
	task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_RANGE_LOW:    cfg_lo = val;
			CFG_RANGE_HIGH:   cfg_hi = val;
			CFG_MATCH_DATA:   cfg_match = val;
			CFG_MATCH_MASK:   cfg_mask = val[MaskW-1:0];
			CFG_FRAME_ID:     cfg_id = val[IdW-1:0];
			CFG_FRAME_LENGTH: cfg_len = val[LenW-1:0];
			CFG_PERIOD_TICKS: cfg_period = val[TicksW-1:0];
			CFG_MODE_FLAGS:   cfg_mode = val[ModeW-1:0];
			default: ;
		endcase
	endtask

	// offer one command item, wait for the handshake, then predict
	task automatic send_command(input logic [OpW-1:0] op, input logic [LenW-1:0] rx_len,
			input logic [PayW-1:0] rx_pay);
		if ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {{(InDataW - LenW - PayW){1'b0}}, rx_pay, rx_len};
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		model_apply_command(op, rx_len, rx_pay);
	endtask

	// command whose rx fields are don't-care
	task automatic send_plain(input logic [OpW-1:0] op);
		send_command(op, LenW'($urandom_range(15)), {$urandom, $urandom});
	endtask

	// hold the input until every expected result is out, then let the pipe clear
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (frames_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// result side: random stalls, plus a counted hold-off on request
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// ---------------------------------------------------------------
	// result check
	// ---------------------------------------------------------------

	task automatic compare_field(input string what, input logic [PayW-1:0] want,
			input logic [PayW-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_check
		frame_result_t want;
		frame_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.tx_id = m_axis_tdata[IdW-1:0];
			got.tx_extended = m_axis_tdata[IdW];
			got.tx_length = m_axis_tdata[IdW+1 +: LenW];
			got.tx_payload = m_axis_tdata[IdW+1+LenW +: PayW];
			got.tx_valid = m_axis_tuser[0];
			got.done_res = m_axis_tuser[1];
			got.done_by_match = m_axis_tuser[2];
			if (frames_due.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual tdata %h tuser %b",
					$time, m_axis_tdata, m_axis_tuser);
				errors++;
			end else begin
				want = frames_due.pop_front();
				compare_field("tx_valid", want.tx_valid, got.tx_valid);
				compare_field("tx_id", want.tx_id, got.tx_id);
				compare_field("tx_extended", want.tx_extended, got.tx_extended);
				compare_field("tx_length", want.tx_length, got.tx_length);
				compare_field("tx_payload", want.tx_payload, got.tx_payload);
				compare_field("done_res", want.done_res, got.done_res);
				compare_field("done_by_match", want.done_by_match, got.done_by_match);
			end
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// reset values: period zero, one byte, bounds zero, so the first frame ends the run
	task automatic test_defaults_after_reset();
		send_plain(OP_START);
		send_plain(OP_TICK);
		drain_results();
	endtask

	// three-digit odometer, middle digit fixed, last byte first, extended id
	task automatic test_odometer_carry();
		write_reg(CFG_RANGE_LOW, 64'hFFFF_FFFF_FF00_0500);
		write_reg(CFG_RANGE_HIGH, 64'hFFFF_FFFF_FF01_0501);
		write_reg(CFG_FRAME_LENGTH, 3);
		write_reg(CFG_FRAME_ID, 29'h1FFF_FFFF);
		write_reg(CFG_MODE_FLAGS, (1 << ModeExtBit) | (1 << ModeUpBit));
		write_reg(CFG_PERIOD_TICKS, 0);
		send_plain(OP_START);
		repeat (4) send_plain(OP_TICK);
		drain_results();
	endtask

	// length zero taken as one, standard id, ticks ignored while paused
	task automatic test_pause_and_short_length();
		write_reg(CFG_RANGE_LOW, 64'h0000_0000_0000_00FE);
		write_reg(CFG_RANGE_HIGH, 64'h0000_0000_0000_00FF);
		write_reg(CFG_FRAME_LENGTH, 0);
		write_reg(CFG_MODE_FLAGS, 0);
		write_reg(CFG_PERIOD_TICKS, 2);
		send_plain(OP_START);
		repeat (2) send_plain(OP_TICK);
		send_plain(OP_PAUSE);
		send_plain(OP_TICK);
		send_plain(OP_RESUME);
		repeat (2) send_plain(OP_TICK);
		drain_results();
	endtask

	// stop on match: short length, wrong byte, hit, then an empty mask
	task automatic test_match_stop();
		logic [PayW-1:0] pattern;
		pattern = 64'h0123_4567_89AB_CDEF;
		write_reg(CFG_MATCH_DATA, pattern);
		write_reg(CFG_MATCH_MASK, 8'hFF);
		write_reg(CFG_FRAME_LENGTH, 15);
		write_reg(CFG_PERIOD_TICKS, PERIOD_MAX);
		write_reg(CFG_MODE_FLAGS, 1 << ModeMatchBit);
		send_plain(OP_START);
		send_command(OP_RX, LenW'(7), pattern);
		send_command(OP_RX, LenW'(15), pattern ^ (64'd1 << 40));
		send_command(OP_RX, LenW'(15), pattern);
		send_command(OP_RX, LenW'(8), pattern);
		drain_results();
		write_reg(CFG_MATCH_MASK, 0);
		send_plain(OP_START);
		send_command(OP_RX, LenW'(0), '1);
		drain_results();
	endtask

	// elapsed count beyond a newly shortened period saturates and fires
	task automatic test_period_saturation();
		write_reg(CFG_RANGE_LOW, 0);
		write_reg(CFG_RANGE_HIGH, 0);
		write_reg(CFG_FRAME_LENGTH, 8);
		write_reg(CFG_MODE_FLAGS, 0);
		write_reg(CFG_PERIOD_TICKS, PERIOD_MAX);
		send_plain(OP_START);
		repeat (2) send_plain(OP_TICK);
		drain_results();
		write_reg(CFG_PERIOD_TICKS, 1);
		send_plain(OP_TICK);
		drain_results();
	endtask

	task automatic test_unused_ops();
		send_plain(OP_SPARE_A);
		send_plain(OP_SPARE_B);
		drain_results();
	endtask

	// long result stall while ticks keep coming, so the input backs up
	task automatic test_backpressure();
		int unsigned saved_src;
		int unsigned saved_snk;
		saved_src = src_idle_pct;
		saved_snk = snk_idle_pct;
		src_idle_pct = 0;
		snk_idle_pct = 0;
		write_reg(CFG_RANGE_LOW, 0);
		write_reg(CFG_RANGE_HIGH, '1);
		write_reg(CFG_FRAME_LENGTH, 8);
		write_reg(CFG_PERIOD_TICKS, 0);
		write_reg(CFG_MODE_FLAGS, 1 << ModeExtBit);
		send_plain(OP_START);
		hold_requests++;
		repeat (80) send_plain(OP_TICK);
		// sender waits here for every result
		drain_results();
		src_idle_pct = saved_src;
		snk_idle_pct = saved_snk;
	endtask

	// random register setup with small odometers so runs wrap often
	task automatic pick_random_setup();
		logic [PayW-1:0] lo;
		logic [PayW-1:0] hi;
		int unsigned b;
		for (int i = 0; i < 8; i++) begin
			case ($urandom_range(9))
				0, 1, 2: begin
					b = $urandom_range(255);
					lo[8*i +: 8] = 8'(b);
					hi[8*i +: 8] = 8'(b);
				end
				7: begin
					// inverted bounds
					b = $urandom_range(8, 255);
					lo[8*i +: 8] = 8'(b);
					hi[8*i +: 8] = 8'(b - $urandom_range(1, 7));
				end
				8: begin
					lo[8*i +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
					hi[8*i +: 8] = lo[8*i +: 8];
				end
				9: begin
					lo[8*i +: 8] = 8'h00;
					hi[8*i +: 8] = 8'hFF;
				end
				default: begin
					b = $urandom_range(252);
					lo[8*i +: 8] = 8'(b);
					hi[8*i +: 8] = 8'(b + $urandom_range(1, 3));
				end
			endcase
		end
		write_reg(CFG_RANGE_LOW, lo);
		write_reg(CFG_RANGE_HIGH, hi);
		write_reg(CFG_MATCH_DATA, {$urandom, $urandom});
		write_reg(CFG_MATCH_MASK, $urandom_range(255));
		write_reg(CFG_FRAME_ID, $urandom_range(29'h1FFF_FFFF));
		write_reg(CFG_FRAME_LENGTH,
			($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 8));
		case ($urandom_range(19))
			0: write_reg(CFG_PERIOD_TICKS, PERIOD_MAX);
			1, 2, 3: write_reg(CFG_PERIOD_TICKS, $urandom_range(4, 12));
			default: write_reg(CFG_PERIOD_TICKS, $urandom_range(3));
		endcase
		write_reg(CFG_MODE_FLAGS, $urandom_range(7));
	endtask

	// received frame built to match, sometimes spoiled by one bit
	task automatic send_matching_rx();
		logic [PayW-1:0] byte_sel;
		logic [PayW-1:0] pay;
		logic [LenW-1:0] len;
		byte_sel = '0;
		for (int i = 0; i < 8; i++)
			if (cfg_mask[i]) byte_sel[8*i +: 8] = 8'hFF;
		pay = ({$urandom, $urandom} & ~byte_sel) | (cfg_match & byte_sel);
		if ($urandom_range(3) == 0) pay[$urandom_range(63)] ^= 1'b1;
		if ($urandom_range(4) == 0) len = LenW'($urandom_range(15));
		else len = LenW'($urandom_range($countones(cfg_mask), 15));
		send_command(OP_RX, len, pay);
	endtask

	task automatic send_random_command();
		int unsigned pick;
		pick = $urandom_range(99);
		if ((!gen_running || gen_finished) && pick < 40) send_plain(OP_START);
		else if (pick < 62) send_plain(OP_TICK);
		else if (pick < 72) send_matching_rx();
		else if (pick < 78) send_plain(OP_PAUSE);
		else if (pick < 86) send_plain(OP_RESUME);
		else if (pick < 90) send_plain(OP_STOP);
		else if (pick < 94) send_plain(OP_START);
		else if (pick < 97) send_plain(OP_RX);
		else send_plain($urandom_range(1) ? OP_SPARE_A : OP_SPARE_B);
	endtask

	// three idle profiles: sender light / receiver heavy, reversed, none
	task automatic test_random_traffic();
		int unsigned goal;
		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 80 : 0;
			snk_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 15 : 0;
			goal = items_sent + TRAFFIC_PER_PHASE;
			while (items_sent < goal) begin
				drain_results();
				pick_random_setup();
				send_plain(OP_START);
				repeat ($urandom_range(20, 60)) send_random_command();
			end
		end
		drain_results();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults_after_reset();
		test_odometer_carry();
		test_pause_and_short_length();
		test_match_stop();
		test_period_saturation();
		test_unused_ops();
		test_backpressure();
		test_random_traffic();
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#1_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
